[hw/rtl/dcrb_pkg.sv]
// Shared types, register map and reset values for the display companion register block.
`default_nettype none

package dcrb_pkg;

   localparam int RegBytes = 15;

   localparam int OfsId       = 0;
   localparam int OfsReset    = 1;
   localparam int OfsDetected = 2;
   localparam int OfsTimeout  = 3;
   localparam int OfsRemain   = 7;
   localparam int OfsBeep     = 11;
   localparam int OfsBright   = 13;

   localparam logic [7:0]  DevId          = 8'h01;
   localparam logic [31:0] TimeoutDefault = 32'd20000;
   localparam logic [15:0] BeepDefault    = 16'd250;
   localparam logic [1:0]  HighNeeded     = 2'd3;
   localparam logic [1:0]  PulsesNeeded   = 2'd2;

   typedef logic [RegBytes-1:0][7:0] regs_type;

   typedef enum logic [2:0] {
      ACT_WR_ADDR    = 3'd0,
      ACT_WR_DATA    = 3'd1,
      ACT_RD_BYTE    = 3'd2,
      ACT_SENSE_EDGE = 3'd3,
      ACT_SAMPLE     = 3'd4,
      ACT_MS_TICK    = 3'd5
   } action_type;

   function automatic regs_type regs_reset_value();
      regs_type r;
      r = '0;
      r[OfsId] = DevId;
      r[OfsTimeout+3:OfsTimeout] = TimeoutDefault;
      r[OfsBeep+1:OfsBeep] = BeepDefault;
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/display_companion_register_block_core.sv]
// Top level: register file, motion qualifier and millisecond housekeeping in one pass.
`default_nettype none

// Display companion register block. Each word on the req_ side is one event
// (bus address/data write, byte read, sensor edge, sensor sample or
// millisecond tick) and produces exactly one word on the rsp_ side. The event
// is applied to the register state in the cycle it is accepted and its result
// sits in the rsp_ output register from the next cycle on. Throughput is 1
// word per cycle. The rate is set by the single state-update
// pass (32-bit remaining-count decrement being the longest path); a new word
// is taken whenever the output register is empty or is being drained.
module display_companion_register_block_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] data_byte, [8] sensor_level, rest zero
   input  wire logic [2:0]  req_tuser,   // [2:0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // [7:0] read_byte, [8] buzzer_on,
                                         // [18:9] backlight_duty, [19] detected,
                                         // [20] reset_request, rest zero
);

   dcrb_pkg::regs_type regs_ff, regs_in;
   logic [7:0]  ptr_ff, ptr_in;
   logic        expect_ff, expect_in;
   logic        armed_ff, armed_in;
   logic [1:0]  high_ff, high_in;
   logic [1:0]  pulse_ff, pulse_in;
   logic [9:0]  duty_ff, duty_in;
   logic        buzz_ff, buzz_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;

   logic        accept;
   logic [7:0]  rd_byte;
   logic        did_reset;
   logic [15:0] bright;
   logic [15:0] beep;
   logic [31:0] remain;
   logic        det_out;
   logic [7:0]  data_byte;
   logic        sensor_level;

   assign data_byte    = req_tdata[7:0];
   assign sensor_level = req_tdata[8];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      regs_in   = regs_ff;
      ptr_in    = ptr_ff;
      expect_in = expect_ff;
      armed_in  = armed_ff;
      high_in   = high_ff;
      pulse_in  = pulse_ff;
      duty_in   = duty_ff;
      buzz_in   = buzz_ff;
      rd_byte   = 8'd0;
      did_reset = 1'b0;
      bright    = regs_ff[dcrb_pkg::OfsBright+1:dcrb_pkg::OfsBright];
      beep      = regs_ff[dcrb_pkg::OfsBeep+1:dcrb_pkg::OfsBeep];
      remain    = regs_ff[dcrb_pkg::OfsRemain+3:dcrb_pkg::OfsRemain] - 32'd1;
      if (accept) begin
         case (dcrb_pkg::action_type'(req_tuser))
            dcrb_pkg::ACT_WR_ADDR: begin
               expect_in = 1'b1;
            end
            dcrb_pkg::ACT_WR_DATA: begin
               if (expect_ff) begin
                  ptr_in    = data_byte;
                  expect_in = 1'b0;
               end else if (ptr_ff < 8'(dcrb_pkg::RegBytes)) begin
                  regs_in[ptr_ff[3:0]] = data_byte;
                  ptr_in = ptr_ff + 8'd1;
               end
            end
            dcrb_pkg::ACT_RD_BYTE: begin
               if (ptr_ff < 8'(dcrb_pkg::RegBytes)) begin
                  rd_byte = regs_ff[ptr_ff[3:0]];
               end
               ptr_in = ptr_ff + 8'd1;
            end
            dcrb_pkg::ACT_SENSE_EDGE: begin
               armed_in = 1'b1;
            end
            dcrb_pkg::ACT_SAMPLE: begin
               if (armed_ff && sensor_level) begin
                  high_in = high_ff + 2'd1;
                  if (high_in >= dcrb_pkg::HighNeeded) begin
                     // qualified pulse: disarm until next edge
                     high_in  = 2'd0;
                     armed_in = 1'b0;
                     pulse_in = pulse_ff + 2'd1;
                  end
               end else begin
                  armed_in = 1'b0;
                  high_in  = 2'd0;
               end
               if (pulse_in > dcrb_pkg::PulsesNeeded) begin
                  regs_in[dcrb_pkg::OfsDetected] = 8'd1;
                  regs_in[dcrb_pkg::OfsRemain+3:dcrb_pkg::OfsRemain] =
                     regs_ff[dcrb_pkg::OfsTimeout+3:dcrb_pkg::OfsTimeout];
                  pulse_in = 2'd0;
               end
            end
            dcrb_pkg::ACT_MS_TICK: begin
               if (regs_ff[dcrb_pkg::OfsReset] == 8'd1) begin
                  // soft reset: restore everything, skip the rest of the tick
                  regs_in   = dcrb_pkg::regs_reset_value();
                  ptr_in    = 8'd0;
                  expect_in = 1'b1;
                  armed_in  = 1'b0;
                  high_in   = 2'd0;
                  pulse_in  = 2'd0;
                  duty_in   = 10'd0;
                  buzz_in   = 1'b0;
                  did_reset = 1'b1;
               end else begin
                  if (bright[15:10] == 6'd0) begin
                     duty_in = bright[9:0];
                  end
                  if (beep != 16'd0) begin
                     buzz_in = 1'b1;
                     regs_in[dcrb_pkg::OfsBeep+1:dcrb_pkg::OfsBeep] = beep - 16'd1;
                  end else begin
                     buzz_in = 1'b0;
                  end
                  if (regs_ff[dcrb_pkg::OfsDetected] == 8'd1) begin
                     regs_in[dcrb_pkg::OfsRemain+3:dcrb_pkg::OfsRemain] = remain;
                     if (remain == 32'd0) begin
                        regs_in[dcrb_pkg::OfsDetected] = 8'd0;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      det_out = (regs_in[dcrb_pkg::OfsDetected] == 8'd1);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'd0, did_reset, det_out, duty_in, buzz_in, rd_byte};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff      <= dcrb_pkg::regs_reset_value();
         ptr_ff       <= 8'd0;
         expect_ff    <= 1'b1;
         armed_ff     <= 1'b0;
         high_ff      <= 2'd0;
         pulse_ff     <= 2'd0;
         duty_ff      <= 10'd0;
         buzz_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         regs_ff      <= regs_in;
         ptr_ff       <= ptr_in;
         expect_ff    <= expect_in;
         armed_ff     <= armed_in;
         high_ff      <= high_in;
         pulse_ff     <= pulse_in;
         duty_ff      <= duty_in;
         buzz_ff      <= buzz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payload while the word waits
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

[test/display_companion_register_block_core_tb.sv]
// Testbench for display_companion_register_block_core: random event words against a predictor.
module display_companion_register_block_core_tb;

   localparam logic [2:0]  ActSpareLo  = 3'd6;
   localparam logic [2:0]  ActSpareHi  = 3'd7;
   localparam logic [15:0] DutyLimit   = 16'd1024;
   localparam int          TargetWords = 1950;
   localparam int          QuietWords  = 250;

   class dcrb_scoreboard;
      logic [7:0]  regs [dcrb_pkg::RegBytes];
      logic [7:0]  ptr;
      bit          want_ptr, armed, buzz;
      logic [1:0]  highs, pulses;
      logic [9:0]  duty;
      logic [23:0] expected_q [$];
      int          errors, checked, reads, soft_resets, detections, expiries;

      function new();
         errors = 0;
         checked = 0;
         reads = 0;
         soft_resets = 0;
         detections = 0;
         expiries = 0;
         restart();
      endfunction

      function void restart();
         foreach (regs[i]) regs[i] = 8'd0;
         regs[dcrb_pkg::OfsId] = dcrb_pkg::DevId;
         store32(dcrb_pkg::OfsTimeout, dcrb_pkg::TimeoutDefault);
         {regs[dcrb_pkg::OfsBeep+1], regs[dcrb_pkg::OfsBeep]} = dcrb_pkg::BeepDefault;
         ptr = 8'd0;
         want_ptr = 1'b1;
         armed = 1'b0;
         highs = 2'd0;
         pulses = 2'd0;
         duty = 10'd0;
         buzz = 1'b0;
      endfunction

      function logic [31:0] field32(int ofs);
         return {regs[ofs+3], regs[ofs+2], regs[ofs+1], regs[ofs]};
      endfunction

      function void store32(int ofs, logic [31:0] v);
         {regs[ofs+3], regs[ofs+2], regs[ofs+1], regs[ofs]} = v;
      endfunction

      // Apply one accepted event word and queue the result word it produces.
      function void note_word(logic [2:0] act, logic [7:0] data, bit level);
         logic [7:0]  rd;
         bit          did_reset;
         logic [15:0] bright, beep;
         logic [31:0] remain;
         rd = 8'd0;
         did_reset = 1'b0;
         case (act)
            dcrb_pkg::ACT_WR_ADDR: want_ptr = 1'b1;
            dcrb_pkg::ACT_WR_DATA: begin
               if (want_ptr) begin
                  ptr = data;
                  want_ptr = 1'b0;
               end else if (ptr < 8'(dcrb_pkg::RegBytes)) begin
                  regs[ptr] = data;
                  ptr = ptr + 8'd1;
               end
            end
            dcrb_pkg::ACT_RD_BYTE: begin
               if (ptr < 8'(dcrb_pkg::RegBytes)) rd = regs[ptr];
               ptr = ptr + 8'd1;
               reads++;
            end
            dcrb_pkg::ACT_SENSE_EDGE: armed = 1'b1;
            dcrb_pkg::ACT_SAMPLE: begin
               if (armed && level) begin
                  highs = highs + 2'd1;
                  if (highs >= dcrb_pkg::HighNeeded) begin
                     highs = 2'd0;
                     armed = 1'b0;
                     pulses = pulses + 2'd1;
                  end
               end else begin
                  armed = 1'b0;
                  highs = 2'd0;
               end
               // third qualified pulse: flag detection and reload the countdown
               if (pulses > dcrb_pkg::PulsesNeeded) begin
                  regs[dcrb_pkg::OfsDetected] = 8'd1;
                  store32(dcrb_pkg::OfsRemain, field32(dcrb_pkg::OfsTimeout));
                  pulses = 2'd0;
                  detections++;
               end
            end
            dcrb_pkg::ACT_MS_TICK: begin
               if (regs[dcrb_pkg::OfsReset] == 8'd1) begin
                  restart();
                  did_reset = 1'b1;
                  soft_resets++;
               end else begin
                  bright = {regs[dcrb_pkg::OfsBright+1], regs[dcrb_pkg::OfsBright]};
                  if (bright < DutyLimit) duty = bright[9:0];
                  beep = {regs[dcrb_pkg::OfsBeep+1], regs[dcrb_pkg::OfsBeep]};
                  if (beep != 16'd0) begin
                     buzz = 1'b1;
                     {regs[dcrb_pkg::OfsBeep+1], regs[dcrb_pkg::OfsBeep]} = beep - 16'd1;
                  end else begin
                     buzz = 1'b0;
                  end
                  if (regs[dcrb_pkg::OfsDetected] == 8'd1) begin
                     remain = field32(dcrb_pkg::OfsRemain) - 32'd1;
                     store32(dcrb_pkg::OfsRemain, remain);
                     if (remain == 32'd0) begin
                        regs[dcrb_pkg::OfsDetected] = 8'd0;
                        expiries++;
                     end
                  end
               end
            end
            default: ;
         endcase
         expected_q.push_back({3'b000, did_reset, regs[dcrb_pkg::OfsDetected] == 8'd1,
                               duty, buzz, rd});
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_word(logic [23:0] got);
         logic [23:0] want;
         if (expected_q.size() == 0) begin
            $error("result word %h arrived with no event pending", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_field("read_byte", 32'(want[7:0]), 32'(got[7:0]));
         compare_field("buzzer_on", 32'(want[8]), 32'(got[8]));
         compare_field("backlight_duty", 32'(want[18:9]), 32'(got[18:9]));
         compare_field("detected", 32'(want[19]), 32'(got[19]));
         compare_field("reset_request", 32'(want[20]), 32'(got[20]));
         compare_field("padding", 32'(want[23:21]), 32'(got[23:21]));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'd0;
   logic [2:0]  req_tuser = dcrb_pkg::ACT_WR_ADDR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   dcrb_scoreboard board = new();
   int words_sent = 0;
   int idle_odds = 0;
   int stall_odds = 0;
   int stall_left = 0;

   display_companion_register_block_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Receiver: hold off in bursts while stall_odds is nonzero.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(16, 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_word(req_tuser, req_tdata[7:0], req_tdata[8]);
         if (rsp_tvalid && rsp_tready)
            board.check_word(rsp_tdata);
      end
   end

   function automatic int pick_odds();
      int v;
      v = $urandom_range(2, 0);
      return (v == 0) ? 0 : ((v == 1) ? 3 : 8);
   endfunction

   task automatic send_word(logic [2:0] act, logic [7:0] data = 8'd0, bit level = 1'b0);
      int gap;
      if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
         gap = $urandom_range(17, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'd0, level, data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // Point at a register byte, then store count bytes of value, low byte first.
   task automatic write_bytes(logic [7:0] where, logic [31:0] value, int count);
      send_word(dcrb_pkg::ACT_WR_ADDR);
      send_word(dcrb_pkg::ACT_WR_DATA, where);
      for (int i = 0; i < count; i++) send_word(dcrb_pkg::ACT_WR_DATA, value[8*i +: 8]);
   endtask

   task automatic motion_pulse(bit clean);
      send_word(dcrb_pkg::ACT_SENSE_EDGE, 8'($urandom_range(255, 0)),
                1'($urandom_range(1, 0)));
      for (int i = 0; i < 3; i++)
         send_word(dcrb_pkg::ACT_SAMPLE, 8'($urandom_range(255, 0)),
                   clean || $urandom_range(5, 0) != 0);
   endtask

   task automatic ms_ticks(int count);
      for (int i = 0; i < count; i++)
         send_word(dcrb_pkg::ACT_MS_TICK, 8'($urandom_range(255, 0)));
   endtask

   task automatic run_random();
      int kind;
      int n;
      while (words_sent < TargetWords) begin
         if (words_sent >= TargetWords - QuietWords) begin
            idle_odds = 0;
            stall_odds = 0;
         end else if ($urandom_range(3, 0) == 0) begin
            idle_odds = pick_odds();
            stall_odds = pick_odds();
         end
         kind = $urandom_range(9, 0);
         case (kind)
            0, 1: begin
               n = $urandom_range(4, 1);
               if ($urandom_range(7, 0) == 0)
                  write_bytes(8'($urandom_range(255, 0)), $urandom(), n);
               else
                  write_bytes(8'($urandom_range(dcrb_pkg::RegBytes - 1, 0)), $urandom(), n);
            end
            2: begin
               if ($urandom_range(1, 0) == 0) begin
                  send_word(dcrb_pkg::ACT_WR_ADDR);
                  if ($urandom_range(3, 0) == 0)
                     send_word(dcrb_pkg::ACT_WR_DATA, 8'($urandom_range(255, 0)));
                  else
                     send_word(dcrb_pkg::ACT_WR_DATA,
                               8'($urandom_range(dcrb_pkg::RegBytes - 1, 0)));
               end
               n = $urandom_range(20, 1);
               for (int i = 0; i < n; i++)
                  send_word(dcrb_pkg::ACT_RD_BYTE, 8'($urandom_range(255, 0)));
            end
            3, 4: begin
               n = $urandom_range(3, 1);
               for (int i = 0; i < n; i++) motion_pulse(1'b0);
            end
            5: ms_ticks($urandom_range(10, 1));
            6: begin
               // short timeout so detections expire, including the zero wrap
               write_bytes(8'(dcrb_pkg::OfsTimeout), $urandom_range(6, 0), 4);
               for (int i = 0; i < 3; i++) motion_pulse(1'b1);
               ms_ticks($urandom_range(10, 1));
            end
            7: begin
               write_bytes(8'(dcrb_pkg::OfsBright), $urandom_range(1100, 0), 2);
               ms_ticks(1);
            end
            8: begin
               write_bytes(8'(dcrb_pkg::OfsReset),
                           ($urandom_range(2, 0) != 0) ? 1 : $urandom_range(255, 0), 1);
               ms_ticks(1);
            end
            default: begin
               n = $urandom_range(4, 1);
               for (int i = 0; i < n; i++)
                  send_word(3'($urandom_range(7, 0)), 8'($urandom_range(255, 0)),
                            1'($urandom_range(1, 0)));
            end
         endcase
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      idle_odds = 3;
      stall_odds = 3;

      // directed: id read, pointer extremes, out-of-range access, duty limit, broken motion pulse, spare action codes
      send_word(dcrb_pkg::ACT_RD_BYTE);
      send_word(dcrb_pkg::ACT_WR_ADDR);
      send_word(dcrb_pkg::ACT_WR_DATA, 8'hff);
      send_word(dcrb_pkg::ACT_WR_DATA, 8'h00);
      send_word(dcrb_pkg::ACT_RD_BYTE);
      send_word(dcrb_pkg::ACT_RD_BYTE);
      write_bytes(8'(dcrb_pkg::OfsBright), 32'hffff, 2);
      send_word(dcrb_pkg::ACT_MS_TICK);
      write_bytes(8'(dcrb_pkg::OfsBright), 32'h03ff, 2);
      send_word(dcrb_pkg::ACT_MS_TICK);
      send_word(dcrb_pkg::ACT_SENSE_EDGE);
      send_word(dcrb_pkg::ACT_SAMPLE, 8'h00, 1'b1);
      send_word(dcrb_pkg::ACT_SAMPLE, 8'h00, 1'b0);
      send_word(ActSpareLo, 8'h5a, 1'b1);
      send_word(ActSpareHi, 8'ha5, 1'b0);
      // soft reset through the reset byte
      write_bytes(8'(dcrb_pkg::OfsReset), 32'h1, 1);
      send_word(dcrb_pkg::ACT_MS_TICK);

      run_random();

      req_tvalid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Checked %0d result words from %0d event words (%0d reads, %0d soft resets).",
               board.checked, words_sent, board.reads, board.soft_resets);
      $display("Motion qualifier raised %0d detections, %0d expired.",
               board.detections, board.expiries);
      if (board.errors == 0) begin
         $display("display_companion_register_block_core test passed");
      end else begin
         $display("display_companion_register_block_core test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("display_companion_register_block_core test failed");
      $finish;
   end

endmodule
